FILE: hw/rtl/text_console_cursor_core_assert.svh
// assertion macros for the text console cursor core
`ifndef TEXT_CONSOLE_CURSOR_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants of the text console cursor core.
// ----------------------------------------------------------------------------
package tcc_pkg;

  typedef enum logic [1:0] {
    FUNC_PUT     = 2'd0,
    FUNC_SET     = 2'd1,
    FUNC_LAST    = 2'd2,
    FUNC_NEWLINE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_REPORT = 2'd2
  } kind_e;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [2:0] TAB_STEP   = 3'd4;

  // request to the shared compare and increment unit
  typedef struct packed {
    logic [7:0] operand;
    logic [7:0] limit;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] inc;
    logic       at_limit;
    logic [7:0] sat;
  } alu_rsp_t;

endpackage

FILE: hw/rtl/tcc_alu.sv
// ----------------------------------------------------------------------------
// tcc_alu
// Shared unit: increment, reached-limit compare and saturation of a coordinate.
// ----------------------------------------------------------------------------
module tcc_alu (
  input  tcc_pkg::alu_req_t req_i,
  output tcc_pkg::alu_rsp_t rsp_o
);

  logic above;

  assign above          = req_i.operand > req_i.limit;
  assign rsp_o.inc      = req_i.operand + 8'd1;
  assign rsp_o.at_limit = above || (req_i.operand == req_i.limit);
  assign rsp_o.sat      = above ? req_i.limit : req_i.operand;

endmodule

FILE: hw/rtl/text_console_cursor_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_core
// Cursor sequencer for a character-cell display: cell writes, scrolls and a
// cursor report per transaction, using one shared compare/increment unit.
// ----------------------------------------------------------------------------
// sequence: a move to the last cell reports in the cycle after acceptance, a
//   set saturates column then row (SATC, SATR) before the report, and
//   characters, tabs and newlines step through writes, line feeds and scrolls
// a new transaction is taken only in idle, after the last report is taken
// reset: rst_ni clears the cursor to column 0, row 0 and returns to idle
module text_console_cursor_core #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] char_code_i,
  input  logic [7:0] set_col_i,
  input  logic [7:0] set_row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] cell_col_o,
  output logic [7:0] cell_row_o,
  output logic [7:0] cell_char_o,
  output logic       last_o
);

  localparam logic [7:0] LastCol = 8'(COLS - 1);
  localparam logic [7:0] LastRow = 8'(ROWS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_WRITE  = 7'b0000010,
    S_LF     = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_SATC   = 7'b0010000,
    S_SATR   = 7'b0100000,
    S_REPORT = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [7:0]        col_q, col_d;
  logic [7:0]        row_q, row_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [7:0]        ch_q, ch_d;
  logic [7:0]        sc_q, sc_d;
  logic [7:0]        sr_q, sr_d;
  tcc_pkg::alu_req_t alu_req;
  tcc_pkg::alu_rsp_t alu_rsp;
  logic              out_xfer;

  tcc_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_WRITE) || (state_q == S_SCROLL) ||
                       (state_q == S_REPORT);
  assign out_xfer    = out_valid_o && out_ready_i;

  always_comb begin
    case (state_q)
      S_LF: begin
        alu_req.operand = row_q;
        alu_req.limit   = LastRow;
      end
      S_SATC: begin
        alu_req.operand = sc_q;
        alu_req.limit   = LastCol;
      end
      S_SATR: begin
        alu_req.operand = sr_q;
        alu_req.limit   = LastRow;
      end
      default: begin
        alu_req.operand = col_q;
        alu_req.limit   = LastCol;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    ch_d    = ch_q;
    sc_d    = sc_q;
    sr_d    = sr_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ch_d  = char_code_i;
          sc_d  = set_col_i;
          sr_d  = set_row_i;
          cnt_d = 3'd0;
          case (tcc_pkg::func_e'(func_i))
            tcc_pkg::FUNC_PUT: begin
              if (char_code_i == tcc_pkg::CH_NEWLINE) begin
                state_d = S_LF;
              end else if (char_code_i == tcc_pkg::CH_TAB) begin
                ch_d    = tcc_pkg::CH_SPACE;
                cnt_d   = tcc_pkg::TAB_STEP - {1'b0, col_q[1:0]};
                state_d = S_WRITE;
              end else begin
                cnt_d   = 3'd1;
                state_d = S_WRITE;
              end
            end
            tcc_pkg::FUNC_SET: begin
              state_d = S_SATC;
            end
            tcc_pkg::FUNC_LAST: begin
              col_d   = LastCol;
              row_d   = LastRow;
              state_d = S_REPORT;
            end
            default: begin
              state_d = (col_q != 8'd0) ? S_LF : S_REPORT;
            end
          endcase
        end
      end
      S_WRITE: begin
        if (out_xfer) begin
          cnt_d = cnt_q - 3'd1;
          if (alu_rsp.at_limit) begin
            state_d = S_LF;
          end else begin
            col_d   = alu_rsp.inc;
            state_d = (cnt_q == 3'd1) ? S_REPORT : S_WRITE;
          end
        end
      end
      S_LF: begin
        col_d = 8'd0;
        if (alu_rsp.at_limit) begin
          state_d = S_SCROLL;
        end else begin
          row_d   = alu_rsp.inc;
          state_d = (cnt_q != 3'd0) ? S_WRITE : S_REPORT;
        end
      end
      S_SCROLL: begin
        if (out_xfer) begin
          state_d = (cnt_q != 3'd0) ? S_WRITE : S_REPORT;
        end
      end
      S_SATC: begin
        col_d   = alu_rsp.sat;
        state_d = S_SATR;
      end
      S_SATR: begin
        row_d   = alu_rsp.sat;
        state_d = S_REPORT;
      end
      S_REPORT: begin
        if (out_xfer) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= 8'd0;
      row_q   <= 8'd0;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    sc_q <= sc_d;
    sr_q <= sr_d;
  end

  always_comb begin
    case (state_q)
      S_WRITE: begin
        kind_o      = tcc_pkg::KIND_WRITE;
        cell_col_o  = col_q;
        cell_row_o  = row_q;
        cell_char_o = ch_q;
        last_o      = 1'b0;
      end
      S_SCROLL: begin
        kind_o      = tcc_pkg::KIND_SCROLL;
        cell_col_o  = 8'd0;
        cell_row_o  = 8'd0;
        cell_char_o = 8'd0;
        last_o      = 1'b0;
      end
      default: begin
        kind_o      = tcc_pkg::KIND_REPORT;
        cell_col_o  = col_q;
        cell_row_o  = row_q;
        cell_char_o = 8'd0;
        last_o      = (state_q == S_REPORT);
      end
    endcase
  end

endmodule

FILE: hw/rtl/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the text console cursor core, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_cursor_core_assert.svh"

module tcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] cell_col_o,
  input logic [7:0] cell_row_o,
  input logic [7:0] cell_char_o,
  input logic       last_o
);

  `TCC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o) && $stable(cell_col_o) && $stable(cell_row_o) && $stable(cell_char_o) && $stable(last_o), "result changed while stalled")
  `TCC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready right after a transaction was taken")
  `TCC_ASSERT_NEXT(a_idle_after_report, out_valid_o && out_ready_i && last_o, in_ready_o && !out_valid_o, "not idle after the report")
  `TCC_ASSERT_NOW(a_last_is_report, out_valid_o, last_o == (kind_o == tcc_pkg::KIND_REPORT), "last flag does not match report kind")

endmodule

bind text_console_cursor_core tcc_checker u_tcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .cell_col_o  (cell_col_o),
  .cell_row_o  (cell_row_o),
  .cell_char_o (cell_char_o),
  .last_o      (last_o)
);
